[design/lrupr_pkg.sv]
package lrupr_pkg;

    localparam int FRAMES_DEF    = 16;
    localparam int PAGE_BITS_DEF = 16;
    localparam int CFG_W         = 5;
    localparam int CFG_RESET     = 16;
    localparam int SLOT_OUT_W    = 4;
    localparam int FAULT_W       = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_AGE,
        ST_COMMIT,
        ST_DONE
    } lru_state_t;

    typedef struct packed {
        logic page_we;
        logic rank_we;
    } tbl_we_t;

endpackage

[design/lrupr_table.sv]
module lrupr_table
    import lrupr_pkg::*;
#(
    parameter int FRAMES    = FRAMES_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] rd_addr,
    output logic [PAGE_BITS-1:0]                   rd_page,
    output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] rd_rank,
    input  tbl_we_t                                we,
    input  logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] wr_addr,
    input  logic [PAGE_BITS-1:0]                   wr_page,
    input  logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] wr_rank
);

    localparam int SLOT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    logic [PAGE_BITS-1:0] page_mem [FRAMES];
    logic [SLOT_W-1:0]    rank_mem [FRAMES];

    always_ff @(posedge aclk) begin
        if (we.page_we) begin
            page_mem[wr_addr] <= wr_page;
        end
        if (we.rank_we) begin
            rank_mem[wr_addr] <= wr_rank;
        end
        rd_page <= page_mem[rd_addr];
        rd_rank <= rank_mem[rd_addr];
    end

endmodule

[design/lru_page_replacement.sv]
// Channel   Ports                                   Direction  Carries
// s_        s_valid s_ready s_page_number           in         page reference
// m_        m_valid m_ready m_hit m_frame_slot      out        lookup result
//           m_evicted_valid m_evicted_page m_fault_count
// cfg_      cfg_valid cfg_ready cfg_frames_in_use   in         frame limit write
//
// One transaction at a time: a new reference is accepted only after the previous result
// has been loaded into the result register.
// The frame table has a single read port and is walked twice: a lookup pass (match and
// oldest rank) and an ageing pass.
// Synchronous active-low reset empties the table and clears the fault count; limit = 16.
// A stalled result register holds the sequencer before it loads the next result.
module lru_page_replacement
    import lrupr_pkg::*;
#(
    parameter int FRAMES    = FRAMES_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [PAGE_BITS-1:0]  s_page_number,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_hit,
    output logic [SLOT_OUT_W-1:0] m_frame_slot,
    output logic                  m_evicted_valid,
    output logic [PAGE_BITS-1:0]  m_evicted_page,
    output logic [FAULT_W-1:0]    m_fault_count,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_W-1:0]      cfg_frames_in_use
);

    localparam int SLOT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W  = $clog2(FRAMES + 1);
    localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    lru_state_t           state_reg, state_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic                 pend_reg, pend_next;
    logic [SLOT_W-1:0]    pend_idx_reg, pend_idx_next;
    logic [PAGE_BITS-1:0] page_reg, page_next;
    logic                 found_reg, found_next;
    logic [SLOT_W-1:0]    hit_slot_reg, hit_slot_next;
    logic [SLOT_W-1:0]    hit_rank_reg, hit_rank_next;
    logic [SLOT_W-1:0]    max_rank_reg, max_rank_next;
    logic [SLOT_W-1:0]    max_slot_reg, max_slot_next;
    logic [PAGE_BITS-1:0] max_page_reg, max_page_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic                 fill_reg, fill_next;
    logic                 evict_reg, evict_next;
    logic [CNT_W-1:0]     filled_reg, filled_next;
    logic [FAULT_W-1:0]   fault_reg, fault_next;
    logic [CFG_W-1:0]     cfg_reg, cfg_next;

    logic                  m_valid_reg, m_valid_next;
    logic                  m_hit_reg, m_hit_next;
    logic [SLOT_W-1:0]     m_slot_reg, m_slot_next;
    logic                  m_ev_valid_reg, m_ev_valid_next;
    logic [PAGE_BITS-1:0]  m_ev_page_reg, m_ev_page_next;
    logic [FAULT_W-1:0]    m_fault_reg, m_fault_next;

    logic [SLOT_W-1:0]    rd_addr;
    logic [PAGE_BITS-1:0] page_q;
    logic [SLOT_W-1:0]    rank_q;
    tbl_we_t              tbl_we;
    logic [SLOT_W-1:0]    wr_addr;
    logic [SLOT_W-1:0]    wr_rank;

    logic                 scan_more;
    logic [CMP_W-1:0]     limit;

    lrupr_table #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_table (
        .aclk    (aclk),
        .rd_addr (rd_addr),
        .rd_page (page_q),
        .rd_rank (rank_q),
        .we      (tbl_we),
        .wr_addr (wr_addr),
        .wr_page (page_reg),
        .wr_rank (wr_rank)
    );

    assign s_ready         = (state_reg == ST_IDLE);
    assign cfg_ready       = 1'b1;
    assign m_valid         = m_valid_reg;
    assign m_hit           = m_hit_reg;
    assign m_frame_slot    = SLOT_OUT_W'(m_slot_reg);
    assign m_evicted_valid = m_ev_valid_reg;
    assign m_evicted_page  = m_ev_page_reg;
    assign m_fault_count   = m_fault_reg;

    assign scan_more = (idx_reg < filled_reg);

    // zero acts as one, anything above the table size as the table size
    always_comb begin
        if (cfg_reg == '0) begin
            limit = CMP_W'(1);
        end else if (CMP_W'(cfg_reg) > CMP_W'(FRAMES)) begin
            limit = CMP_W'(FRAMES);
        end else begin
            limit = CMP_W'(cfg_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            pend_reg    <= 1'b0;
            found_reg   <= 1'b0;
            fill_reg    <= 1'b0;
            evict_reg   <= 1'b0;
            filled_reg  <= '0;
            fault_reg   <= '0;
            cfg_reg     <= CFG_W'(CFG_RESET);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            pend_reg    <= pend_next;
            found_reg   <= found_next;
            fill_reg    <= fill_next;
            evict_reg   <= evict_next;
            filled_reg  <= filled_next;
            fault_reg   <= fault_next;
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_idx_reg   <= pend_idx_next;
        page_reg       <= page_next;
        hit_slot_reg   <= hit_slot_next;
        hit_rank_reg   <= hit_rank_next;
        max_rank_reg   <= max_rank_next;
        max_slot_reg   <= max_slot_next;
        max_page_reg   <= max_page_next;
        slot_reg       <= slot_next;
        m_hit_reg      <= m_hit_next;
        m_slot_reg     <= m_slot_next;
        m_ev_valid_reg <= m_ev_valid_next;
        m_ev_page_reg  <= m_ev_page_next;
        m_fault_reg    <= m_fault_next;
    end

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        page_next       = page_reg;
        found_next      = found_reg;
        hit_slot_next   = hit_slot_reg;
        hit_rank_next   = hit_rank_reg;
        max_rank_next   = max_rank_reg;
        max_slot_next   = max_slot_reg;
        max_page_next   = max_page_reg;
        slot_next       = slot_reg;
        fill_next       = fill_reg;
        evict_next      = evict_reg;
        filled_next     = filled_reg;
        fault_next      = fault_reg;
        cfg_next        = cfg_reg;
        m_valid_next    = m_valid_reg;
        m_hit_next      = m_hit_reg;
        m_slot_next     = m_slot_reg;
        m_ev_valid_next = m_ev_valid_reg;
        m_ev_page_next  = m_ev_page_reg;
        m_fault_next    = m_fault_reg;

        tbl_we  = '0;
        rd_addr = SLOT_W'(idx_reg);
        wr_addr = pend_idx_reg;
        wr_rank = SLOT_W'(rank_q + 1'b1);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cfg_valid) begin
            cfg_next = cfg_frames_in_use;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    page_next     = s_page_number;
                    idx_next      = '0;
                    pend_next     = 1'b0;
                    found_next    = 1'b0;
                    max_rank_next = '0;
                    max_slot_next = '0;
                    max_page_next = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                pend_next     = scan_more;
                pend_idx_next = SLOT_W'(idx_reg);
                if (scan_more) begin
                    idx_next = idx_reg + 1'b1;
                end
                if (pend_reg) begin
                    if (!found_reg && page_q == page_reg) begin
                        found_next    = 1'b1;
                        hit_slot_next = pend_idx_reg;
                        hit_rank_next = rank_q;
                    end
                    if (pend_idx_reg == '0 || rank_q > max_rank_reg) begin
                        max_rank_next = rank_q;
                        max_slot_next = pend_idx_reg;
                        max_page_next = page_q;
                    end
                end
                if (!scan_more && !pend_reg) begin
                    fill_next  = !found_reg && (CMP_W'(filled_reg) < limit);
                    evict_next = !found_reg && !(CMP_W'(filled_reg) < limit);
                    if (found_reg) begin
                        slot_next = hit_slot_reg;
                    end else if (CMP_W'(filled_reg) < limit) begin
                        slot_next = SLOT_W'(filled_reg);
                    end else begin
                        slot_next = max_slot_reg;
                    end
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    state_next = ST_AGE;
                end
            end
            ST_AGE: begin
                pend_next     = scan_more;
                pend_idx_next = SLOT_W'(idx_reg);
                if (scan_more) begin
                    idx_next = idx_reg + 1'b1;
                end
                // a miss ages every frame; a hit ages only frames more recent than it
                if (pend_reg && (!found_reg || rank_q < hit_rank_reg)) begin
                    tbl_we.rank_we = 1'b1;
                end
                if (!scan_more && !pend_reg) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                wr_addr        = slot_reg;
                wr_rank        = '0;
                tbl_we.rank_we = 1'b1;
                tbl_we.page_we = !found_reg;
                if (fill_reg) begin
                    filled_next = filled_reg + 1'b1;
                end
                if (!found_reg && fault_reg != {FAULT_W{1'b1}}) begin
                    fault_next = fault_reg + 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_hit_next      = found_reg;
                    m_slot_next     = slot_reg;
                    m_ev_valid_next = evict_reg;
                    m_ev_page_next  = evict_reg ? max_page_reg : '0;
                    m_fault_next    = fault_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_filled_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        filled_reg <= CNT_W'(FRAMES))
        else $error("filled frame count beyond table size");

    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_hit_reg |-> !m_ev_valid_reg)
        else $error("hit reported with an eviction");

    a_fault_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> fault_reg >= $past(fault_reg))
        else $error("fault count went backwards");

    a_fault_on_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_COMMIT |=> $stable(fault_reg))
        else $error("fault count moved outside commit");

endmodule

[test/tb_lru_page_replacement.sv]
module tb_lru_page_replacement;
    import lrupr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT  = 2000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 200;
    localparam int SETTLE_TICKS = 64;

    typedef struct packed {
        logic                     hit;
        logic [SLOT_OUT_W-1:0]    slot;
        logic                     ev_valid;
        logic [PAGE_BITS_DEF-1:0] ev_page;
        logic [FAULT_W-1:0]       faults;
    } lookup_t;

    typedef enum bit {
        ROW_LOOKUP,
        ROW_LIMIT
    } row_kind_t;

    typedef struct packed {
        row_kind_t                kind;
        logic [PAGE_BITS_DEF-1:0] value;
        logic                     typed;
        lookup_t                  want;
    } dir_row_t;

    localparam lookup_t NO_WANT = '0;

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [PAGE_BITS_DEF-1:0] s_page_number;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic                     m_hit;
    logic [SLOT_OUT_W-1:0]    m_frame_slot;
    logic                     m_evicted_valid;
    logic [PAGE_BITS_DEF-1:0] m_evicted_page;
    logic [FAULT_W-1:0]       m_fault_count;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_W-1:0]         cfg_frames_in_use;

    // shadow of the frame table
    logic [PAGE_BITS_DEF-1:0] slot_page [FRAMES_DEF];
    logic [3:0]               slot_age  [FRAMES_DEF];
    int unsigned              slots_filled;
    logic [FAULT_W-1:0]       fault_tally;
    logic [CFG_W-1:0]         limit_reg;

    lookup_t  lookups_due [$];
    dir_row_t script [$];
    int       failures;
    int       quiet_ticks = 0;
    int       src_idle_pct;
    int       sink_stall_pct;

    lru_page_replacement DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_page_number     (s_page_number),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_hit             (m_hit),
        .m_frame_slot      (m_frame_slot),
        .m_evicted_valid   (m_evicted_valid),
        .m_evicted_page    (m_evicted_page),
        .m_fault_count     (m_fault_count),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_frames_in_use (cfg_frames_in_use)
    );

    always #5ns aclk = ~aclk;

    function automatic lookup_t predict_lookup(input logic [PAGE_BITS_DEF-1:0] page);
        lookup_t     r;
        int unsigned cap;
        int unsigned count;
        int unsigned oldest;
        logic [3:0]  hit_age;
        r = '0;
        count = slots_filled;
        cap = (limit_reg == 0) ? 1 : ((limit_reg > FRAMES_DEF) ? FRAMES_DEF : limit_reg);
        for (int j = 0; j < count; j++) begin
            if (!r.hit && slot_page[j] == page) begin
                r.hit  = 1'b1;
                r.slot = SLOT_OUT_W'(j);
            end
        end
        if (r.hit) begin
            hit_age = slot_age[r.slot];
            for (int j = 0; j < count; j++) begin
                if (slot_age[j] < hit_age) slot_age[j] = slot_age[j] + 1'b1;
            end
            slot_age[r.slot] = '0;
        end else begin
            if (count < cap) begin
                r.slot = SLOT_OUT_W'(count);
                slots_filled = count + 1;
            end else begin
                oldest = 0;
                for (int j = 0; j < count; j++) begin
                    if (slot_age[j] > oldest) begin
                        oldest = slot_age[j];
                        r.slot = SLOT_OUT_W'(j);
                    end
                end
                r.ev_valid = 1'b1;
                r.ev_page  = slot_page[r.slot];
            end
            for (int j = 0; j < count; j++) slot_age[j] = slot_age[j] + 1'b1;
            slot_page[r.slot] = page;
            slot_age[r.slot]  = '0;
            if (fault_tally != '1) fault_tally = fault_tally + 1'b1;
        end
        r.faults = fault_tally;
        return r;
    endfunction

    function automatic void add_row(input dir_row_t r);
        script.insert(script.size(), r);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
        end
    endfunction

    task automatic send_page(input logic [PAGE_BITS_DEF-1:0] page, input logic typed,
                             input lookup_t want);
        lookup_t got;
        @(negedge aclk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_page_number <= page;
        do @(posedge aclk); while (!s_ready);
        got = predict_lookup(page);
        lookups_due.insert(lookups_due.size(), typed ? want : got);
    endtask

    // lowers valid, then waits for every pending result
    task automatic drain_lookups();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (lookups_due.size() != 0) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [CFG_W-1:0] value);
        @(negedge aclk);
        cfg_valid         <= 1'b1;
        cfg_frames_in_use <= value;
        do @(posedge aclk); while (!cfg_ready);
        limit_reg = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    always @(negedge aclk) m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);

    always @(posedge aclk) begin
        lookup_t want;
        if (aresetn && m_valid && m_ready) begin
            if (lookups_due.size() == 0) begin
                $error("result transaction with nothing pending");
                failures++;
            end else begin
                want = lookups_due.pop_front();
                check_field("m_hit", want.hit, m_hit);
                check_field("m_frame_slot", want.slot, m_frame_slot);
                check_field("m_evicted_valid", want.ev_valid, m_evicted_valid);
                check_field("m_evicted_page", want.ev_page, m_evicted_page);
                check_field("m_fault_count", want.faults, m_fault_count);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_ticks <= 0;
        end else if (quiet_ticks + 1 >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_ticks <= quiet_ticks + 1;
        end
    end

    initial begin
        logic [CFG_W-1:0]         phase_limit [PHASES];
        logic [PAGE_BITS_DEF-1:0] hot_pages [32];
        logic [PAGE_BITS_DEF-1:0] pg;
        logic [CFG_W-1:0]         lim;
        int                       span;
        dir_row_t                 row;

        aresetn           = 1'b0;
        s_valid           = 1'b0;
        s_page_number     = '0;
        cfg_valid         = 1'b0;
        cfg_frames_in_use = '0;
        failures          = 0;
        src_idle_pct      = 0;
        sink_stall_pct    = 0;
        slots_filled      = 0;
        fault_tally       = '0;
        limit_reg         = CFG_RESET;
        for (int j = 0; j < FRAMES_DEF; j++) begin
            slot_page[j] = '0;
            slot_age[j]  = '0;
        end
        phase_limit = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd8, 5'd2, 5'd15, 5'd16};

        // kind, value, typed, hit, slot, ev_valid, ev_page, faults
        add_row({ROW_LOOKUP, 16'h0000, 1'b1, 1'b0, 4'd0, 1'b0, 16'h0000, 32'd1});
        add_row({ROW_LOOKUP, 16'hFFFF, 1'b1, 1'b0, 4'd1, 1'b0, 16'h0000, 32'd2});
        add_row({ROW_LOOKUP, 16'h0000, 1'b1, 1'b1, 4'd0, 1'b0, 16'h0000, 32'd2});
        add_row({ROW_LOOKUP, 16'hFFFF, 1'b1, 1'b1, 4'd1, 1'b0, 16'h0000, 32'd2});
        // zero limit acts as one, and sits below the filled count
        add_row({ROW_LIMIT,  16'd0,    1'b0, NO_WANT});
        add_row({ROW_LOOKUP, 16'h1234, 1'b0, NO_WANT});
        add_row({ROW_LOOKUP, 16'hFFFF, 1'b0, NO_WANT});
        add_row({ROW_LOOKUP, 16'h5555, 1'b0, NO_WANT});
        add_row({ROW_LOOKUP, 16'h0000, 1'b0, NO_WANT});
        // above the table size: clamps, filling resumes
        add_row({ROW_LIMIT,  16'd31,   1'b0, NO_WANT});
        add_row({ROW_LOOKUP, 16'hAAAA, 1'b0, NO_WANT});
        add_row({ROW_LOOKUP, 16'h0001, 1'b0, NO_WANT});
        add_row({ROW_LOOKUP, 16'h8000, 1'b0, NO_WANT});
        add_row({ROW_LOOKUP, 16'h7FFF, 1'b0, NO_WANT});
        add_row({ROW_LOOKUP, 16'h5555, 1'b0, NO_WANT});
        add_row({ROW_LIMIT,  16'd3,    1'b0, NO_WANT});
        add_row({ROW_LOOKUP, 16'h0F0F, 1'b0, NO_WANT});
        add_row({ROW_LOOKUP, 16'hF0F0, 1'b0, NO_WANT});
        add_row({ROW_LOOKUP, 16'h0001, 1'b0, NO_WANT});
        add_row({ROW_LOOKUP, 16'h0F0F, 1'b0, NO_WANT});
        add_row({ROW_LIMIT,  16'd1,    1'b0, NO_WANT});
        add_row({ROW_LOOKUP, 16'h3C3C, 1'b0, NO_WANT});
        add_row({ROW_LOOKUP, 16'h3C3C, 1'b0, NO_WANT});
        add_row({ROW_LIMIT,  16'd16,   1'b0, NO_WANT});
        add_row({ROW_LOOKUP, 16'hC3C3, 1'b0, NO_WANT});
        add_row({ROW_LOOKUP, 16'h0000, 1'b0, NO_WANT});

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (script[i]) begin
            row = script[i];
            if (row.kind == ROW_LIMIT) begin
                drain_lookups();
                write_limit(row.value[CFG_W-1:0]);
            end else begin
                send_page(row.value, row.typed, row.want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_lookups();
            lim = phase_limit[ph];
            if (ph == 5) lim = CFG_W'($urandom_range(0, 31));
            write_limit(lim);
            case (ph % 4)
                0: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct   = 71;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 71;
                end
                default: begin
                    src_idle_pct   = 11;
                    sink_stall_pct = 11;
                end
            endcase
            foreach (hot_pages[k]) hot_pages[k] = PAGE_BITS_DEF'($urandom);
            span = $urandom_range(2, 32);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == 100 || $urandom_range(0, 199) == 0) drain_lookups();
                if ($urandom_range(0, 99) < 80) pg = hot_pages[$urandom_range(0, span - 1)];
                else pg = PAGE_BITS_DEF'($urandom);
                send_page(pg, 1'b0, NO_WANT);
            end
        end

        drain_lookups();
        repeat (SETTLE_TICKS) @(posedge aclk);
        if (failures == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
